// ===== rtl/core/mpk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpk_pkg
// Shared types, event codes and format tables for the MessagePack tokenizer.
// ----------------------------------------------------------------------------
package mpk_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned KIND_W  = 4;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned FLEFT_W = 4;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind EV_UINT     = 4'd0;
    localparam t_kind EV_INT      = 4'd1;
    localparam t_kind EV_F32      = 4'd2;
    localparam t_kind EV_F64      = 4'd3;
    localparam t_kind EV_NIL      = 4'd4;
    localparam t_kind EV_FALSE    = 4'd5;
    localparam t_kind EV_TRUE     = 4'd6;
    localparam t_kind EV_MAP      = 4'd7;
    localparam t_kind EV_ARRAY    = 4'd8;
    localparam t_kind EV_STR_HDR  = 4'd9;
    localparam t_kind EV_STR_BYTE = 4'd10;
    localparam t_kind EV_ERROR    = 4'd11;

    typedef enum logic [2:0] {
        PH_FORMAT   = 3'd0,
        PH_FIELD    = 3'd1,
        PH_EXT_TYPE = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_SKIP     = 3'd4,
        PH_DONE     = 3'd5
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic [DATA_W-1:0]    fmt;
        logic [FLEFT_W-1:0]   field_left;
        logic [VALUE_W-1:0]   acc;
        logic [COUNT_W-1:0]   payload_left;
        logic [COUNT_W-1:0]   objects_left;
        logic                 err;
    } t_state;

    typedef struct packed {
        t_kind                kind;
        logic [VALUE_W-1:0]   value;
        logic                 last;
        logic                 done;
    } t_event;

    localparam t_state ST_RESET = '{
        phase:        PH_FORMAT,
        fmt:          '0,
        field_left:   '0,
        acc:          '0,
        payload_left: '0,
        objects_left: COUNT_W'(1),
        err:          1'b0
    };

    // Length/value field width in bytes for codes 0xc0..0xdf.
    function automatic logic [FLEFT_W-1:0] field_width(input logic [4:0] idx);
        logic [FLEFT_W-1:0] w;
        unique case (idx)
            5'h04, 5'h07, 5'h0c, 5'h10, 5'h19:                    w = 4'd1;
            5'h05, 5'h08, 5'h0d, 5'h11, 5'h1a, 5'h1c, 5'h1e:      w = 4'd2;
            5'h06, 5'h09, 5'h0a, 5'h0e, 5'h12, 5'h1b, 5'h1d,
            5'h1f:                                                w = 4'd4;
            5'h0b, 5'h0f, 5'h13:                                  w = 4'd8;
            default:                                              w = 4'd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mpk_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpk_step
// Next-state and event logic of the tokenizer for one stream byte.
// ----------------------------------------------------------------------------
module mpk_step (
    input  wire mpk_pkg::t_state i_state,
    input  wire logic [7:0]      i_byte,
    output mpk_pkg::t_state      o_state,
    output logic                 o_ev_valid,
    output mpk_pkg::t_event      o_event
);
    import mpk_pkg::*;

    t_state              n;
    logic                fin;
    logic                fin_emit;
    t_kind               fin_kind;
    logic [VALUE_W-1:0]  fin_value;
    logic                fin_last;
    logic                cont;
    logic                cont_map;
    logic [COUNT_W-1:0]  cont_count;
    logic                str;
    logic [COUNT_W-1:0]  str_len;
    logic                err;
    logic [VALUE_W-1:0]  acc_n;
    logic [FLEFT_W-1:0]  left_n;
    logic [COUNT_W-1:0]  pl_n;
    logic [COUNT_W-1:0]  obj_dec;
    logic [COUNT_W:0]    entries;
    logic [COUNT_W+1:0]  total;
    logic                overflow;
    logic [VALUE_W-1:0]  sext;

    assign acc_n   = {i_state.acc[VALUE_W-DATA_W-1:0], i_byte};
    assign left_n  = (i_state.field_left != '0) ? i_state.field_left - 4'd1 : '0;
    assign pl_n    = (i_state.payload_left != '0) ? i_state.payload_left - 32'd1 : '0;
    assign obj_dec = (i_state.objects_left != '0) ? i_state.objects_left - 32'd1 : '0;

    always_comb begin
        unique case (i_state.fmt[1:0])
            2'd0:    sext = {{56{acc_n[7]}}, acc_n[7:0]};
            2'd1:    sext = {{48{acc_n[15]}}, acc_n[15:0]};
            2'd2:    sext = {{32{acc_n[31]}}, acc_n[31:0]};
            default: sext = acc_n;
        endcase
    end

    always_comb begin
        n          = i_state;
        fin        = 1'b0;
        fin_emit   = 1'b0;
        fin_kind   = EV_UINT;
        fin_value  = '0;
        fin_last   = 1'b0;
        cont       = 1'b0;
        cont_map   = 1'b0;
        cont_count = '0;
        str        = 1'b0;
        str_len    = '0;
        err        = 1'b0;

        if (!i_state.err) begin
            unique case (i_state.phase)
                PH_FORMAT: begin
                    if (i_byte < 8'h80) begin
                        fin = 1'b1; fin_emit = 1'b1;
                        fin_kind = EV_UINT; fin_value = {57'd0, i_byte[6:0]};
                    end else if (i_byte >= 8'he0) begin
                        fin = 1'b1; fin_emit = 1'b1;
                        fin_kind = EV_INT; fin_value = {{59{1'b1}}, i_byte[4:0]};
                    end else if (i_byte < 8'h90) begin
                        cont = 1'b1; cont_map = 1'b1; cont_count = {28'd0, i_byte[3:0]};
                    end else if (i_byte < 8'ha0) begin
                        cont = 1'b1; cont_count = {28'd0, i_byte[3:0]};
                    end else if (i_byte < 8'hc0) begin
                        str = 1'b1; str_len = {27'd0, i_byte[4:0]};
                    end else begin
                        unique case (i_byte)
                            8'hc0: begin fin = 1'b1; fin_emit = 1'b1; fin_kind = EV_NIL; end
                            8'hc1: err = 1'b1;
                            8'hc2: begin fin = 1'b1; fin_emit = 1'b1; fin_kind = EV_FALSE; end
                            8'hc3: begin fin = 1'b1; fin_emit = 1'b1; fin_kind = EV_TRUE; end
                            8'hd4: begin n.payload_left = 32'd1;  n.phase = PH_EXT_TYPE; end
                            8'hd5: begin n.payload_left = 32'd2;  n.phase = PH_EXT_TYPE; end
                            8'hd6: begin n.payload_left = 32'd4;  n.phase = PH_EXT_TYPE; end
                            8'hd7: begin n.payload_left = 32'd8;  n.phase = PH_EXT_TYPE; end
                            8'hd8: begin n.payload_left = 32'd16; n.phase = PH_EXT_TYPE; end
                            default: begin
                                n.fmt        = i_byte;
                                n.field_left = field_width(i_byte[4:0]);
                                n.acc        = '0;
                                n.phase      = PH_FIELD;
                            end
                        endcase
                    end
                end
                PH_FIELD: begin
                    n.acc        = acc_n;
                    n.field_left = left_n;
                    if (left_n == '0) begin
                        unique case (i_state.fmt)
                            8'hca: begin
                                fin = 1'b1; fin_emit = 1'b1;
                                fin_kind = EV_F32; fin_value = {32'd0, acc_n[31:0]};
                            end
                            8'hcb: begin
                                fin = 1'b1; fin_emit = 1'b1;
                                fin_kind = EV_F64; fin_value = acc_n;
                            end
                            8'hcc, 8'hcd, 8'hce, 8'hcf: begin
                                fin = 1'b1; fin_emit = 1'b1;
                                fin_kind = EV_UINT; fin_value = acc_n;
                            end
                            8'hd0, 8'hd1, 8'hd2, 8'hd3: begin
                                fin = 1'b1; fin_emit = 1'b1;
                                fin_kind = EV_INT; fin_value = sext;
                            end
                            8'hc4, 8'hc5, 8'hc6, 8'hd9, 8'hda, 8'hdb: begin
                                str = 1'b1; str_len = acc_n[31:0];
                            end
                            8'hc7, 8'hc8, 8'hc9: begin
                                n.payload_left = acc_n[31:0];
                                n.phase        = PH_EXT_TYPE;
                            end
                            8'hdc, 8'hdd: begin
                                cont = 1'b1; cont_count = acc_n[31:0];
                            end
                            8'hde, 8'hdf: begin
                                cont = 1'b1; cont_map = 1'b1; cont_count = acc_n[31:0];
                            end
                            default: err = 1'b1;
                        endcase
                    end
                end
                PH_EXT_TYPE: begin
                    if (i_state.payload_left == '0) begin
                        fin = 1'b1;
                    end else begin
                        n.phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n.payload_left = pl_n;
                    if (pl_n == '0) begin
                        fin = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n.payload_left = pl_n;
                    fin_kind       = EV_STR_BYTE;
                    fin_value      = {56'd0, i_byte};
                    if (pl_n == '0) begin
                        fin = 1'b1; fin_emit = 1'b1; fin_last = 1'b1;
                    end else begin
                        fin_emit = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // String headers with zero length complete the object right away.
        if (str) begin
            fin_kind  = EV_STR_HDR;
            fin_value = {32'd0, str_len};
            fin_emit  = 1'b1;
            if (str_len == '0) begin
                fin = 1'b1;
            end else begin
                n.payload_left = str_len;
                n.phase        = PH_PAYLOAD;
            end
        end
    end

    assign entries  = cont_map ? {cont_count, 1'b0} : {1'b0, cont_count};
    assign total    = {2'b00, i_state.objects_left} + {1'b0, entries} - 34'd1;
    assign overflow = (i_state.objects_left == '0) || (total[COUNT_W+1:COUNT_W] != 2'b00);

    always_comb begin
        o_state    = n;
        o_ev_valid = 1'b0;
        o_event    = '0;
        if (err || (cont && overflow)) begin
            o_state.err   = 1'b1;
            o_ev_valid    = 1'b1;
            o_event.kind  = EV_ERROR;
        end else if (cont) begin
            o_state.objects_left = total[COUNT_W-1:0];
            o_state.phase        = (total[COUNT_W-1:0] == '0) ? PH_DONE : PH_FORMAT;
            o_ev_valid           = 1'b1;
            o_event.kind         = cont_map ? EV_MAP : EV_ARRAY;
            o_event.value        = {32'd0, cont_count};
            o_event.done         = (total[COUNT_W-1:0] == '0);
        end else if (fin) begin
            o_state.objects_left = obj_dec;
            o_state.phase        = (obj_dec == '0) ? PH_DONE : PH_FORMAT;
            o_ev_valid           = fin_emit;
            o_event.kind         = fin_kind;
            o_event.value        = fin_value;
            o_event.last         = fin_last;
            o_event.done         = (obj_dec == '0);
        end else begin
            o_ev_valid    = fin_emit;
            o_event.kind  = fin_kind;
            o_event.value = fin_value;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/msgpack_stream_tokenizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msgpack_stream_tokenizer
// Streaming MessagePack tokenizer: one byte in, at most one event out.
// ----------------------------------------------------------------------------
// Takes one MessagePack byte per cycle and emits one event per scalar, map or
// array start, string/binary header and payload byte; extension objects are
// skipped silently. Throughput is one byte per clock, sustained, while the
// output is ready. The event of an accepted byte passes from the input byte
// register through the combinational decode into the event register, where it
// can be taken. A stalled event holds the byte behind it, so the input stalls
// with the output.
// An error (code 0xc1 or an object count overflowing 32 bits) gives one error
// event, after which all input is consumed without events until reset; the
// same holds after the event that carries document_done.
module msgpack_stream_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] event_value
    output logic [4:0]       m_axis_tuser,   // [3:0] event_kind, [4] document_done
    output logic             m_axis_tlast    // payload_last
);
    import mpk_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_state      r_state;
    t_state      w_next;
    logic        w_ev_valid;
    t_event      w_event;
    logic        r_out_valid;
    t_event      r_out;
    logic        w_advance;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;

    mpk_step u_step (
        .i_state    (r_state),
        .i_byte     (r_in_byte),
        .o_state    (w_next),
        .o_ev_valid (w_ev_valid),
        .o_event    (w_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid && w_ev_valid;
                if (r_in_valid) begin
                    r_state <= w_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_advance) begin
            r_out <= w_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.value;
    assign m_axis_tuser  = {r_out.done, r_out.kind};
    assign m_axis_tlast  = r_out.last;

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DONE && !r_out_valid) |=> !r_out_valid)
        else $error("event produced after document completion");

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.err && !r_out_valid) |=> !r_out_valid)
        else $error("event produced after latched error");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[3:0] == EV_STR_BYTE))
        else $error("payload_last on a non-payload event");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[3:0] == EV_ERROR) |-> (!m_axis_tuser[4] && r_state.err))
        else $error("error event without latched error or with done");

endmodule
`default_nettype wire
